// ===== src/pose_gated_descriptor_matcher_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pose gated descriptor matcher
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef POSE_GATED_DESCRIPTOR_MATCHER_ASSERT_SVH
`define POSE_GATED_DESCRIPTOR_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS
// A condition that must hold at every clock edge.
`define PGDM_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("pgdm assertion failed");
// A condition that must hold in the same cycle as its trigger.
`define PGDM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pgdm assertion failed");
// A condition that must hold in the cycle after its trigger.
`define PGDM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pgdm assertion failed");
`else
`define PGDM_ASSERT_ALWAYS(label, cond)
`define PGDM_ASSERT_IMPLY(label, ante, cons)
`define PGDM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/pgdm_pkg.sv =====
// ---------------------------------------------------------------------------
// Pose gated descriptor matcher package
// Sizes, register indexes, shared types and a helper function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgdm_pkg;

    // Store size and descriptor length.
    localparam int MAX_POINTS = 64;
    localparam int DESC_BITS  = 256;
    localparam int DESC_WORDS = (DESC_BITS + 63) / 64;

    // Derived widths.
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int HD_W  = $clog2(DESC_BITS + 1);

    // Fixed field widths.
    localparam int COORD_W = 16;
    localparam int QIDX_W  = 12;
    localparam int TIDX_W  = 6;
    localparam int HOUT_W  = 9;
    localparam int CFG_W   = 17;
    localparam int CFG_A_W = 3;
    localparam int IN_TDATA_W  = 304;
    localparam int OUT_TDATA_W = 32;

    // Transform arithmetic widths.
    localparam int XF_W  = 40;   // products and sums in 2^-18 pixel units
    localparam int XY_W  = 27;   // rounded Q.4 position
    localparam int DD_W  = 28;   // coordinate difference
    localparam int SQ_W  = 56;   // one squared difference
    localparam int D2_W  = 57;   // squared distance
    localparam int LIM_W = 32;   // squared gate radius

    // Input tdata bit positions.
    localparam int QIDX_LSB = 0;
    localparam int KPX_LSB  = 12;
    localparam int KPY_LSB  = 28;
    localparam int DESC_LSB = 44;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes.
    localparam logic [CFG_A_W-1:0] REG_ROT_COS   = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_ROT_SIN   = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_SHIFT_X   = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_SHIFT_Y   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_PIVOT_X   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_PIVOT_Y   = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_DIST_LIM  = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_HAM_LIM   = 3'd7;

    // Register reset values.
    localparam logic [15:0] ROT_COS_RST  = 16'd16384;
    localparam logic [15:0] DIST_LIM_RST = 16'd160;
    localparam logic [8:0]  HAM_LIM_RST  = 9'd180;

    // One stored keypoint.
    typedef struct packed {
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [DESC_BITS-1:0] desc;
    } point_t;

    // Controls shared by every cell of the ring.
    typedef struct packed {
        logic rotate;
        logic load;
    } cell_ctl_t;

    // One candidate leaving the compare pipeline.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [HD_W-1:0]  hd;
    } match_t;

    // Number of ones in a 64-bit word.
    function automatic logic [6:0] popcount64(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int k = 0; k < 64; k++) begin
            n = n + 7'(v[k]);
        end
        return n;
    endfunction

endpackage

// ===== src/pgdm_cell.sv =====
// ---------------------------------------------------------------------------
// Keypoint cell
// Holds one stored keypoint; loads it from the input or takes its
// neighbor's keypoint when the ring rotates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgdm_cell (
    input  logic               aclk,
    input  pgdm_pkg::cell_ctl_t ctl,
    input  logic               sel,
    input  pgdm_pkg::point_t   load_pt,
    input  pgdm_pkg::point_t   nbr_pt,
    output pgdm_pkg::point_t   pt
);
    import pgdm_pkg::*;

    point_t pt_reg;

    // Rotation has priority; loads only happen while the ring is parked.
    always_ff @(posedge aclk) begin
        if (ctl.rotate) begin
            pt_reg <= nbr_pt;
        end else if (ctl.load && sel) begin
            pt_reg <= load_pt;
        end
    end

    assign pt = pt_reg;

endmodule

// ===== src/pgdm_eval.sv =====
// ---------------------------------------------------------------------------
// Candidate evaluator
// Three-stage pipeline that gates one stored keypoint per cycle, while adv
// is high, on pixel distance and descriptor Hamming distance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgdm_eval (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  logic                                 in_valid,
    input  logic [pgdm_pkg::IDX_W-1:0]           in_idx,
    input  pgdm_pkg::point_t                     in_pt,
    input  logic signed [pgdm_pkg::XY_W-1:0]     qx,
    input  logic signed [pgdm_pkg::XY_W-1:0]     qy,
    input  logic [pgdm_pkg::DESC_BITS-1:0]       qdesc,
    input  logic [pgdm_pkg::LIM_W-1:0]           lim2,
    input  logic [8:0]                           ham_lim,
    output pgdm_pkg::match_t                     res,
    output logic                                 busy
);
    import pgdm_pkg::*;

    localparam int PAD_W = DESC_WORDS * 64;

    // Stage 1: differences and descriptor XOR.
    logic                    v1_reg;
    logic [IDX_W-1:0]        i1_reg;
    logic signed [DD_W-1:0]  dx_reg, dy_reg;
    logic [PAD_W-1:0]        xr_reg;

    // Stage 2: squares and per-word counts.
    logic                    v2_reg;
    logic [IDX_W-1:0]        i2_reg;
    logic [SQ_W-1:0]         sx_reg, sy_reg;
    logic [6:0]              pc_reg [DESC_WORDS];

    // Stage 3: gate decision.
    logic                    v3_reg;
    match_t                  m3_reg;

    logic [HD_W-1:0]         hd_sum;
    logic [D2_W-1:0]         d2;

    // Valid bits move with the pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1 payload.
    always_ff @(posedge aclk) begin
        if (adv) begin
            i1_reg <= in_idx;
            dx_reg <= DD_W'(qx) - $signed({{(DD_W-COORD_W){1'b0}}, in_pt.x});
            dy_reg <= DD_W'(qy) - $signed({{(DD_W-COORD_W){1'b0}}, in_pt.y});
            xr_reg <= PAD_W'(qdesc ^ in_pt.desc);
        end
    end

    // Stage 2 payload.
    always_ff @(posedge aclk) begin
        if (adv) begin
            i2_reg <= i1_reg;
            sx_reg <= SQ_W'(dx_reg * dx_reg);
            sy_reg <= SQ_W'(dy_reg * dy_reg);
            for (int w = 0; w < DESC_WORDS; w++) begin
                pc_reg[w] <= popcount64(xr_reg[w*64 +: 64]);
            end
        end
    end

    // Sum of word counts and squared distance.
    always_comb begin
        hd_sum = '0;
        for (int w = 0; w < DESC_WORDS; w++) begin
            hd_sum = hd_sum + HD_W'(pc_reg[w]);
        end
        d2 = D2_W'(sx_reg) + D2_W'(sy_reg);
    end

    // Stage 3 payload.
    always_ff @(posedge aclk) begin
        if (adv) begin
            m3_reg.idx <= i2_reg;
            m3_reg.hd  <= hd_sum;
            m3_reg.hit <= (d2 < D2_W'(lim2)) && (9'(hd_sum) < ham_lim);
        end
    end

    always_comb begin
        res     = m3_reg;
        res.hit = m3_reg.hit && v3_reg;
    end

    assign busy = v1_reg || v2_reg || v3_reg;

endmodule

// ===== src/pose_gated_descriptor_matcher.sv =====
// ---------------------------------------------------------------------------
// Pose gated descriptor matcher
// Stores test keypoints in a rotating ring of cells and matches each
// query keypoint, moved by a pose transform, against all of them.
// ---------------------------------------------------------------------------
// A load item stores one keypoint unless the store is full. A query item
// passes the pose transform (ST_XF1, ST_XF2), a scan in which the ring
// rotates every stored keypoint past the single compare pipeline, the
// draining of that pipeline and the final result. No next item is accepted
// until the final result is formed. An output stall stops the ring and
// pipeline. Results leave in store order, one per match, with the last one
// flagged; a query without matches yields one empty result.
`timescale 1ns / 1ps

`include "pose_gated_descriptor_matcher_assert.svh"

module pose_gated_descriptor_matcher (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Configuration write port.
    input  logic                                    cfg_wr_en,
    input  logic [pgdm_pkg::CFG_A_W-1:0]            cfg_addr,
    input  logic [pgdm_pkg::CFG_W-1:0]              cfg_wr_data,
    // Input items.
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // ref_index, kp_x, kp_y, desc_word0, desc_word1, desc_word2, desc_word3
    input  logic [pgdm_pkg::IN_TDATA_W-1:0]         s_tdata,
    // op, restart
    input  logic [1:0]                              s_tuser,
    // Result items.
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // query_index, test_index, hamming_dist
    output logic [pgdm_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // found
    output logic                                    m_tuser,
    output logic                                    m_tlast
);
    import pgdm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_XF1   = 3'd1;
    localparam logic [2:0] ST_XF2   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    // Configuration registers.
    logic signed [15:0] rot_cos_reg, rot_sin_reg;
    logic signed [16:0] shift_x_reg, shift_y_reg;
    logic [15:0]        pivot_x_reg;
    logic [16:0]        pivot_y_reg;
    logic [15:0]        dist_lim_reg;
    logic [8:0]         ham_lim_reg;

    logic [2:0]         state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   step_reg;

    // Query holding registers.
    logic [QIDX_W-1:0]        qidx_reg;
    logic [COORD_W-1:0]       qx_in_reg, qy_in_reg;
    logic [DESC_BITS-1:0]     qdesc_reg;
    logic signed [33:0]       cu_reg, su_reg, cv_reg, sv_reg;
    logic signed [XY_W-1:0]   x4_reg, y4_reg;
    logic [LIM_W-1:0]         lim2_reg;

    // Pending match and output register.
    logic                pend_valid_reg;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic [HD_W-1:0]     pend_hd_reg;
    logic                m_valid_reg;
    logic [QIDX_W-1:0]   m_qidx_reg;
    logic [TIDX_W-1:0]   m_tidx_reg;
    logic [HOUT_W-1:0]   m_hd_reg;
    logic                m_found_reg;
    logic                m_last_reg;

    logic                adv;
    logic                in_acc;
    logic                out_load;
    logic [CNT_W-1:0]    cnt_base;
    cell_ctl_t           ctl;
    point_t              load_pt;
    point_t              ring [MAX_POINTS];
    match_t              res;
    logic                eval_busy;
    logic                scan_valid;

    logic signed [17:0]      u_s, v_s;
    logic signed [XF_W-1:0]  xf, yf, xr, yr;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign cnt_base = s_tuser[1] ? '0 : count_reg;

    // The output register takes a new item on the final result or when a
    // new match pushes out the one held before it.
    assign out_load = adv && ((state_reg == ST_FINAL) || (res.hit && pend_valid_reg));

    // Ring controls and the keypoint offered for loading.
    assign ctl.rotate   = (state_reg == ST_SCAN) && adv;
    assign ctl.load     = in_acc && (s_tuser[0] == OP_LOAD) && (cnt_base < CNT_W'(MAX_POINTS));
    assign load_pt.x    = s_tdata[KPX_LSB +: COORD_W];
    assign load_pt.y    = s_tdata[KPY_LSB +: COORD_W];
    assign load_pt.desc = s_tdata[DESC_LSB +: DESC_BITS];

    // Ring of cells; cell zero feeds the compare pipeline.
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        localparam int NXT = (i + 1) % MAX_POINTS;
        pgdm_cell u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .sel     (cnt_base == CNT_W'(i)),
            .load_pt (load_pt),
            .nbr_pt  (ring[NXT]),
            .pt      (ring[i])
        );
    end

    assign scan_valid = (state_reg == ST_SCAN) && (step_reg < count_reg);

    pgdm_eval u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (scan_valid),
        .in_idx   (step_reg[IDX_W-1:0]),
        .in_pt    (ring[0]),
        .qx       (x4_reg),
        .qy       (y4_reg),
        .qdesc    (qdesc_reg),
        .lim2     (lim2_reg),
        .ham_lim  (ham_lim_reg),
        .res      (res),
        .busy     (eval_busy)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_cos_reg  <= ROT_COS_RST;
            rot_sin_reg  <= '0;
            shift_x_reg  <= '0;
            shift_y_reg  <= '0;
            pivot_x_reg  <= '0;
            pivot_y_reg  <= '0;
            dist_lim_reg <= DIST_LIM_RST;
            ham_lim_reg  <= HAM_LIM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ROT_COS:  rot_cos_reg  <= cfg_wr_data[15:0];
                REG_ROT_SIN:  rot_sin_reg  <= cfg_wr_data[15:0];
                REG_SHIFT_X:  shift_x_reg  <= cfg_wr_data;
                REG_SHIFT_Y:  shift_y_reg  <= cfg_wr_data;
                REG_PIVOT_X:  pivot_x_reg  <= cfg_wr_data[15:0];
                REG_PIVOT_Y:  pivot_y_reg  <= cfg_wr_data;
                REG_DIST_LIM: dist_lim_reg <= cfg_wr_data[15:0];
                REG_HAM_LIM:  ham_lim_reg  <= cfg_wr_data[8:0];
                default: ;
            endcase
        end
    end

    // Pose transform operands.
    assign u_s = $signed({2'b00, pivot_x_reg}) - $signed({2'b00, qx_in_reg});
    assign v_s = $signed({1'b0, pivot_y_reg}) - $signed({2'b00, qy_in_reg});

    // Transformed position before rounding, in 2^-18 pixel units.
    assign xf = $signed({{(XF_W-30){1'b0}}, pivot_x_reg, 14'd0})
              - (XF_W'(sv_reg) + XF_W'(cu_reg) + XF_W'($signed({shift_y_reg, 14'd0})));
    assign yf = $signed({{(XF_W-31){1'b0}}, pivot_y_reg, 14'd0})
              - (XF_W'(cv_reg) - XF_W'(su_reg) + XF_W'($signed({shift_x_reg, 14'd0})));
    assign xr = xf + XF_W'(8192);
    assign yr = yf + XF_W'(8192);

    // Query datapath registers.
    always_ff @(posedge aclk) begin
        if (in_acc && s_tuser[0] == OP_QUERY) begin
            qidx_reg  <= s_tdata[QIDX_LSB +: QIDX_W];
            qx_in_reg <= s_tdata[KPX_LSB +: COORD_W];
            qy_in_reg <= s_tdata[KPY_LSB +: COORD_W];
            qdesc_reg <= s_tdata[DESC_LSB +: DESC_BITS];
        end
        if (state_reg == ST_XF1) begin
            cu_reg   <= 34'(rot_cos_reg * u_s);
            su_reg   <= 34'(rot_sin_reg * u_s);
            cv_reg   <= 34'(rot_cos_reg * v_s);
            sv_reg   <= 34'(rot_sin_reg * v_s);
            lim2_reg <= LIM_W'(dist_lim_reg * dist_lim_reg);
        end
        if (state_reg == ST_XF2) begin
            x4_reg <= XY_W'($signed(xr[XF_W-1:14]));
            y4_reg <= XY_W'($signed(yr[XF_W-1:14]));
        end
    end

    // Sequencer, store fill count and result collection.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc && s_tuser[0] == OP_LOAD) begin
                        count_reg <= ctl.load ? cnt_base + 1'b1 : cnt_base;
                    end else if (in_acc) begin
                        state_reg <= ST_XF1;
                    end
                end
                ST_XF1: state_reg <= ST_XF2;
                ST_XF2: begin
                    step_reg       <= '0;
                    pend_valid_reg <= 1'b0;
                    state_reg      <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (adv) begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == CNT_W'(MAX_POINTS - 1)) begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!eval_busy) begin
                        state_reg <= ST_FINAL;
                    end
                end
                ST_FINAL: begin
                    if (adv) begin
                        m_qidx_reg  <= qidx_reg;
                        m_found_reg <= pend_valid_reg;
                        m_last_reg  <= 1'b1;
                        m_tidx_reg  <= pend_valid_reg ? TIDX_W'(pend_idx_reg) : '0;
                        m_hd_reg    <= pend_valid_reg ? HOUT_W'(pend_hd_reg) : '0;
                        pend_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // A new match releases the one held before it as a non-final item.
            if (adv && res.hit) begin
                pend_valid_reg <= 1'b1;
                pend_idx_reg   <= res.idx;
                pend_hd_reg    <= res.hd;
                if (pend_valid_reg) begin
                    m_qidx_reg  <= qidx_reg;
                    m_tidx_reg  <= TIDX_W'(pend_idx_reg);
                    m_hd_reg    <= HOUT_W'(pend_hd_reg);
                    m_found_reg <= 1'b1;
                    m_last_reg  <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_hd_reg, m_tidx_reg, m_qidx_reg};
    assign m_tuser  = m_found_reg;
    assign m_tlast  = m_last_reg;

    // The fill count never passes the store size.
    `PGDM_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(MAX_POINTS))
    // An empty answer always closes its query.
    `PGDM_ASSERT_IMPLY(a_empty_last, m_tvalid && !m_tuser, m_tlast)
    // The store is untouched while a query is in flight.
    `PGDM_ASSERT_NEXT(a_count_hold, state_reg != ST_IDLE, $stable(count_reg))
    // The compare pipeline is empty once the final result is formed.
    `PGDM_ASSERT_IMPLY(a_final_idle, state_reg == ST_FINAL, !eval_busy)

endmodule

// ===== tb/pgdm_checker.sv =====
// ---------------------------------------------------------------------------
// Pose gated descriptor matcher checker
// Watches the configuration port and both streams, keeps its own copy of the
// pose registers and keypoint store, and compares every result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgdm_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pgdm_pkg::CFG_A_W-1:0]        cfg_addr,
    input  logic [pgdm_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [pgdm_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [1:0]                          s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [pgdm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                m_tuser,
    input  logic                                m_tlast,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  match_count,
    output int                                  empty_count
);
    import pgdm_pkg::*;

    typedef struct packed {
        logic [11:0] qidx;
        logic [5:0]  tidx;
        logic [8:0]  hd;
        logic        found;
        logic        last;
    } match_res_t;

    // Shadow registers and store.
    logic signed [15:0] cos_q, sin_q;
    logic signed [16:0] shx, shy;
    logic [15:0] pvx;
    logic [16:0] pvy;
    logic [15:0] dlim;
    logic [8:0]  hlim;
    logic [15:0] sx [MAX_POINTS];
    logic [15:0] sy [MAX_POINTS];
    logic [255:0] sdesc [MAX_POINTS];
    int npts;
    match_res_t expected_matches[$];

    function automatic longint round_to_q4(longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    // Work out the results of one query against the current store.
    task automatic predict_query(input logic [11:0] q, input logic [15:0] kx,
                                 input logic [15:0] ky, input logic [255:0] d);
        longint c, s, u, v, xf, yf, x4, y4, dx, dy, d2, lim2;
        int hd, n;
        match_res_t r;
        c = cos_q; s = sin_q;
        u = longint'(pvx) - longint'(kx);
        v = longint'(pvy) - longint'(ky);
        xf = longint'(pvx) * 16384 - (s * v + c * u + longint'(shy) * 16384);
        yf = longint'(pvy) * 16384 - (c * v - s * u + longint'(shx) * 16384);
        x4 = round_to_q4(xf);
        y4 = round_to_q4(yf);
        lim2 = longint'(dlim) * longint'(dlim);
        n = 0;
        for (int j = 0; j < npts; j++) begin
            dx = x4 - longint'(sx[j]);
            dy = y4 - longint'(sy[j]);
            d2 = dx * dx + dy * dy;
            if (d2 < lim2) begin
                hd = $countones(d ^ sdesc[j]);
                if (hd < hlim) begin
                    r = '{q, 6'(j), 9'(hd), 1'b1, 1'b0};
                    expected_matches.insert(expected_matches.size(), r);
                    n++;
                end
            end
        end
        if (n == 0) begin
            r = '{q, 6'd0, 9'd0, 1'b0, 1'b1};
            expected_matches.insert(expected_matches.size(), r);
        end else begin
            expected_matches[expected_matches.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        match_res_t got, want;
        if (!aresetn) begin
            cos_q <= 16'sd16384; sin_q <= '0; shx <= '0; shy <= '0;
            pvx <= '0; pvy <= '0; dlim <= 16'd160; hlim <= 9'd180;
            npts = 0;
            fail_count <= 0; match_count <= 0; empty_count <= 0;
            expected_matches.delete();
        end else begin
            // Register writes.
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ROT_COS:  cos_q <= cfg_wr_data[15:0];
                    REG_ROT_SIN:  sin_q <= cfg_wr_data[15:0];
                    REG_SHIFT_X:  shx <= cfg_wr_data;
                    REG_SHIFT_Y:  shy <= cfg_wr_data;
                    REG_PIVOT_X:  pvx <= cfg_wr_data[15:0];
                    REG_PIVOT_Y:  pvy <= cfg_wr_data;
                    REG_DIST_LIM: dlim <= cfg_wr_data[15:0];
                    REG_HAM_LIM:  hlim <= cfg_wr_data[8:0];
                    default: ;
                endcase
            end
            // Accepted input item.
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_LOAD) begin
                    if (s_tuser[1]) npts = 0;
                    if (npts < MAX_POINTS) begin
                        sx[npts] = s_tdata[KPX_LSB +: 16];
                        sy[npts] = s_tdata[KPY_LSB +: 16];
                        sdesc[npts] = s_tdata[DESC_LSB +: 256];
                        npts++;
                    end
                end else begin
                    predict_query(s_tdata[QIDX_LSB +: 12], s_tdata[KPX_LSB +: 16],
                                  s_tdata[KPY_LSB +: 16], s_tdata[DESC_LSB +: 256]);
                end
            end
            // Accepted result item.
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[11:0], m_tdata[17:12], m_tdata[26:18], m_tuser, m_tlast};
                if (got.found) match_count <= match_count + 1;
                else empty_count <= empty_count + 1;
                if (expected_matches.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected result item: %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_matches.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("Mismatch: expected %p, got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        // Results still owed to the stimulus side.
        pending_count = expected_matches.size();
    end

endmodule

// ===== tb/tb_pose_gated_descriptor_matcher.sv =====
// ---------------------------------------------------------------------------
// Pose gated descriptor matcher testbench
// Drives loads and queries under several pose and gate settings with random
// gaps on both streams; a checker module predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pose_gated_descriptor_matcher;
    import pgdm_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;   // ref_index, kp_x, kp_y, desc_word0..3
    logic [1:0] s_tuser = '0;              // op, restart
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;       // query_index, test_index, hamming_dist
    logic m_tuser;                         // found
    logic m_tlast;
    int fail_count, pending_count, match_count, empty_count;
    int idle_cycles = 0;
    int loads_sent = 0, queries_sent = 0;
    logic [15:0] base_x [MAX_POINTS];
    logic [15:0] base_y [MAX_POINTS];
    logic [255:0] base_d [MAX_POINTS];
    int nbase = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    pose_gated_descriptor_matcher dut (.*);

    pgdm_checker u_checker (.*);

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("pose_gated_descriptor_matcher test failed");
            $finish;
        end
    end

    // Result side: random stall before each item, some stretches without.
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk iff m_tvalid);
        end
    end

    // The write enable stays high until the next send or drain lowers it.
    task automatic write_reg(input logic [CFG_A_W-1:0] a, input logic [CFG_W-1:0] d);
        s_tvalid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wr_data <= d;
        @(posedge aclk);
    endtask

    // The valid stays high after acceptance until a gap, a register write or a drain lowers it.
    task automatic send_item(input logic op, input logic rst, input logic [11:0] q,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [255:0] d);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        cfg_wr_en <= 1'b0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {rst, op};
        s_tdata <= {4'd0, d, y, x, q};
        @(posedge aclk iff s_tready);
        if (op == OP_LOAD) loads_sent++;
        else queries_sent++;
    endtask

    function automatic logic [255:0] rand_desc();
        return {$urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // Toggle nflip randomly chosen bits so Hamming distances sit near the gate.
    function automatic logic [255:0] perturb(input logic [255:0] d, input int nflip);
        for (int k = 0; k < nflip; k++) d[$urandom_range(0, 255)] ^= 1'b1;
        return d;
    endfunction

    task automatic load_point(input logic rst, input logic [15:0] x, input logic [15:0] y,
                              input logic [255:0] d);
        if (rst) nbase = 0;
        if (nbase < MAX_POINTS) begin
            base_x[nbase] = x; base_y[nbase] = y; base_d[nbase] = d; nbase++;
        end
        send_item(OP_LOAD, rst, 12'($urandom()), x, y, d);
    endtask

    // Wait for all results, then let a query in flight drain.
    task automatic drain();
        s_tvalid <= 1'b0;
        cfg_wr_en <= 1'b0;
        @(posedge aclk iff pending_count == 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_pose(input logic [16:0] c, input logic [16:0] s, input logic [16:0] tx,
                            input logic [16:0] ty, input logic [16:0] px,
                            input logic [16:0] py, input logic [16:0] dl,
                            input logic [16:0] hl);
        write_reg(REG_ROT_COS, c);
        write_reg(REG_ROT_SIN, s);
        write_reg(REG_SHIFT_X, tx);
        write_reg(REG_SHIFT_Y, ty);
        write_reg(REG_PIVOT_X, px);
        write_reg(REG_PIVOT_Y, py);
        write_reg(REG_DIST_LIM, dl);
        write_reg(REG_HAM_LIM, hl);
    endtask

    // Random phase: reload the store, then mix further loads, queries near stored points and fully random items.
    task automatic random_phase(input int nitems);
        int j;
        logic [255:0] d;
        load_point(1'b1, 16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                   rand_desc());
        for (int i = 1; i < nitems; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: load_point(1'b0, 16'($urandom_range(0, 4000)),
                                    16'($urandom_range(0, 4000)), rand_desc());
                9: send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             12'($urandom()), 16'($urandom()), 16'($urandom()), rand_desc());
                default: begin
                    j = $urandom_range(0, nbase - 1);
                    d = perturb(base_d[j], $urandom_range(0, 200));
                    send_item(OP_QUERY, 1'($urandom_range(0, 1)), 12'($urandom()),
                              base_x[j] + 16'($urandom_range(0, 64)) - 16'd32,
                              base_y[j] + 16'($urandom_range(0, 64)) - 16'd32, d);
                end
            endcase
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty store, identity pose at reset values.
        send_item(OP_QUERY, 1'b0, 12'hFFF, 16'h0, 16'h0, '0);
        load_point(1'b0, 16'h0, 16'h0, '0);
        load_point(1'b0, 16'hFFFF, 16'hFFFF, '1);
        load_point(1'b0, 16'd100, 16'd100, '1);
        send_item(OP_QUERY, 1'b1, 12'd0, 16'd0, 16'd0, '0);
        send_item(OP_QUERY, 1'b0, 12'd1, 16'hFFFF, 16'hFFFF, '1);
        send_item(OP_QUERY, 1'b0, 12'd2, 16'd100, 16'd100, '0);
        // Restart empties the store.
        load_point(1'b1, 16'd50, 16'd60, 256'h5);
        send_item(OP_QUERY, 1'b0, 12'd3, 16'd50, 16'd60, 256'h4);
        drain();

        // Fill beyond capacity; extra loads are dropped.
        for (int i = 0; i < MAX_POINTS + 2; i++)
            load_point(i == 0, 16'd200, 16'd200, i[0] ? '1 : '0);
        write_reg(REG_HAM_LIM, 17'd257);
        send_item(OP_QUERY, 1'b0, 12'd4, 16'd200, 16'd200, '0);
        drain();
        write_reg(REG_HAM_LIM, 17'd0);
        send_item(OP_QUERY, 1'b0, 12'd5, 16'd200, 16'd200, '0);
        drain();

        // Extreme pose and gate settings.
        set_pose(17'h1C000, 17'h1C000, 17'h10000, 17'h0FFFF, 17'hFFFF, 17'h1FFFF,
                 17'hFFFF, 17'd257);
        send_item(OP_QUERY, 1'b0, 12'd6, 16'hFFFF, 16'h0, '0);
        send_item(OP_QUERY, 1'b0, 12'd7, 16'h0, 16'hFFFF, '1);
        drain();
        set_pose(17'd16384, 17'd16384, 17'h0FFFF, 17'h10000, 17'd0, 17'd0, 17'd0, 17'd180);
        send_item(OP_QUERY, 1'b0, 12'd8, 16'd200, 16'd200, '0);
        drain();

        // Random phases under several poses.
        set_pose(17'd16384, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd160, 17'd180);
        random_phase(25);
        set_pose(17'd16384, 17'd0, 17'd0, 17'd0, 17'd20480, 17'd40000, 17'hFFFF, 17'd257);
        random_phase(20);
        set_pose(17'd16305, 17'd1606, 17'h1FFE0, 17'd24, 17'd20480, 17'd30000, 17'd800,
                 17'd140);
        random_phase(25);
        set_pose(17'h1C000, 17'd0, 17'd0, 17'd0, 17'd2000, 17'd2000, 17'd400, 17'd200);
        random_phase(20);

        $display("Covered %0d loads and %0d queries; %0d match and %0d empty results.",
                 loads_sent, queries_sent, match_count, empty_count);
        if (fail_count == 0) begin
            $display("pose_gated_descriptor_matcher test passed");
        end else begin
            $display("pose_gated_descriptor_matcher test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/pgdm_pkg.sv
src/pgdm_cell.sv
src/pgdm_eval.sv
src/pose_gated_descriptor_matcher.sv
tb/pgdm_checker.sv
tb/tb_pose_gated_descriptor_matcher.sv
